// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker file of the heap queue
// clocked on clk; the gated form is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define MHPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("heap queue check failed");

// checked on every edge, reset included
`define MHPQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("heap queue reset check failed");

`endif

// ----- rtl/core/mhpq_pkg.sv -----
// shared types, codes and sizes of the heap queue
// no dependencies
package mhpq_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int OP_W         = 2;
  localparam int ID_W         = 16;
  localparam int KEY_W        = 32;
  localparam int ST_W         = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_UPDATE = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_RD,
    S_SRCH,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_PLACE,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_LOAD_INS,
    ACT_POP_TAKE,
    ACT_SCAN,
    ACT_FOUND,
    ACT_UP_MOVE,
    ACT_DN_MOVE
  } act_t;

  typedef enum logic [1:0] {
    RD_ROOT_LAST,
    RD_SCAN,
    RD_PARENT,
    RD_CHILDREN
  } rd_t;

  typedef struct packed {
    act_t    act;
    rd_t     rd;
    logic    place;
    logic    set_status;
    status_t status;
    logic    push_out;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic hole_zero;
    logic leaf;
    logic parent_gt;
    logic child_lt;
    logic id_match;
    logic scan_last;
    logic key_lt;
    logic key_gt;
    logic out_busy;
  } sts_t;

endpackage

// ----- rtl/core/mhpq_req_if.sv -----
// request channel of the heap queue: valid/ready plus operation fields
// depends on mhpq_pkg
interface mhpq_req_if;
  logic                        valid;
  logic                        ready;
  logic [mhpq_pkg::OP_W-1:0]   op;
  logic [mhpq_pkg::ID_W-1:0]   node_id;
  logic [mhpq_pkg::KEY_W-1:0]  distance;

  modport source (output valid, op, node_id, distance, input ready);
  modport sink (input valid, op, node_id, distance, output ready);
endinterface

// ----- rtl/core/mhpq_rsp_if.sv -----
// result channel of the heap queue: valid/ready plus result fields
// depends on mhpq_pkg
interface mhpq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [mhpq_pkg::ID_W-1:0]   out_node_id;
  logic [mhpq_pkg::KEY_W-1:0]  out_distance;
  logic [mhpq_pkg::ST_W-1:0]   status;

  modport source (output valid, out_node_id, out_distance, status, input ready);
  modport sink (input valid, out_node_id, out_distance, status, output ready);
endinterface

// ----- rtl/core/mhpq_ctrl.sv -----
// controller of the heap queue: sequences insert, pop, search and sifts
// depends on mhpq_pkg; drives mhpq_datapath through cmd_t / sts_t
module mhpq_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [mhpq_pkg::OP_W-1:0] in_op,
  output logic                      in_ready,
  output mhpq_pkg::cmd_t            cmd,
  input  mhpq_pkg::sts_t            sts
);

  mhpq_pkg::state_t state_r;
  mhpq_pkg::state_t state_nxt;
  logic             acc;

  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mhpq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mhpq_pkg::S_IDLE: begin
        if (acc) begin
          unique case (in_op)
            mhpq_pkg::OP_INSERT: begin
              state_nxt = sts.cnt_full ? mhpq_pkg::S_DONE : mhpq_pkg::S_UP_RD;
            end
            mhpq_pkg::OP_POP: begin
              state_nxt = sts.cnt_zero ? mhpq_pkg::S_DONE : mhpq_pkg::S_POP_RD;
            end
            mhpq_pkg::OP_UPDATE: begin
              state_nxt = sts.cnt_zero ? mhpq_pkg::S_DONE : mhpq_pkg::S_SRCH;
            end
            default: begin
              state_nxt = mhpq_pkg::S_DONE;
            end
          endcase
        end
      end
      mhpq_pkg::S_POP_RD: begin
        state_nxt = mhpq_pkg::S_DN_RD;
      end
      mhpq_pkg::S_SRCH: begin
        if (sts.id_match) begin
          if (sts.key_lt) begin
            state_nxt = mhpq_pkg::S_UP_RD;
          end else if (sts.key_gt) begin
            state_nxt = mhpq_pkg::S_DN_RD;
          end else begin
            state_nxt = mhpq_pkg::S_PLACE;
          end
        end else if (sts.scan_last) begin
          state_nxt = mhpq_pkg::S_DONE;
        end
      end
      mhpq_pkg::S_UP_RD: begin
        state_nxt = sts.hole_zero ? mhpq_pkg::S_PLACE : mhpq_pkg::S_UP_CMP;
      end
      mhpq_pkg::S_UP_CMP: begin
        state_nxt = sts.parent_gt ? mhpq_pkg::S_UP_RD : mhpq_pkg::S_PLACE;
      end
      mhpq_pkg::S_DN_RD: begin
        state_nxt = sts.leaf ? mhpq_pkg::S_PLACE : mhpq_pkg::S_DN_CMP;
      end
      mhpq_pkg::S_DN_CMP: begin
        state_nxt = sts.child_lt ? mhpq_pkg::S_DN_RD : mhpq_pkg::S_PLACE;
      end
      mhpq_pkg::S_PLACE: begin
        state_nxt = mhpq_pkg::S_DONE;
      end
      mhpq_pkg::S_DONE: begin
        if (!sts.out_busy) begin
          state_nxt = mhpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mhpq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.act        = mhpq_pkg::ACT_NONE;
    cmd.rd         = mhpq_pkg::RD_ROOT_LAST;
    cmd.place      = 1'b0;
    cmd.set_status = 1'b0;
    cmd.status     = mhpq_pkg::ST_OK;
    cmd.push_out   = 1'b0;
    unique case (state_r)
      mhpq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (acc) begin
          cmd.act = mhpq_pkg::ACT_LOAD;
          unique case (in_op)
            mhpq_pkg::OP_INSERT: begin
              if (sts.cnt_full) begin
                cmd.set_status = 1'b1;
                cmd.status     = mhpq_pkg::ST_FULL;
              end else begin
                cmd.act = mhpq_pkg::ACT_LOAD_INS;
              end
            end
            mhpq_pkg::OP_POP: begin
              if (sts.cnt_zero) begin
                cmd.set_status = 1'b1;
                cmd.status     = mhpq_pkg::ST_EMPTY;
              end
            end
            mhpq_pkg::OP_UPDATE: begin
              if (sts.cnt_zero) begin
                cmd.set_status = 1'b1;
                cmd.status     = mhpq_pkg::ST_ABSENT;
              end
            end
            default: begin
              cmd.act = mhpq_pkg::ACT_LOAD;
            end
          endcase
        end
      end
      mhpq_pkg::S_POP_RD: begin
        cmd.act = mhpq_pkg::ACT_POP_TAKE;
      end
      mhpq_pkg::S_SRCH: begin
        cmd.rd = mhpq_pkg::RD_SCAN;
        if (sts.id_match) begin
          cmd.act = mhpq_pkg::ACT_FOUND;
        end else if (sts.scan_last) begin
          cmd.set_status = 1'b1;
          cmd.status     = mhpq_pkg::ST_ABSENT;
        end else begin
          cmd.act = mhpq_pkg::ACT_SCAN;
        end
      end
      mhpq_pkg::S_UP_RD: begin
        cmd.rd = mhpq_pkg::RD_PARENT;
      end
      mhpq_pkg::S_UP_CMP: begin
        cmd.rd = mhpq_pkg::RD_PARENT;
        if (sts.parent_gt) begin
          cmd.act = mhpq_pkg::ACT_UP_MOVE;
        end
      end
      mhpq_pkg::S_DN_RD: begin
        cmd.rd = mhpq_pkg::RD_CHILDREN;
      end
      mhpq_pkg::S_DN_CMP: begin
        cmd.rd = mhpq_pkg::RD_CHILDREN;
        if (sts.child_lt) begin
          cmd.act = mhpq_pkg::ACT_DN_MOVE;
        end
      end
      mhpq_pkg::S_PLACE: begin
        cmd.place = 1'b1;
      end
      mhpq_pkg::S_DONE: begin
        cmd.push_out = !sts.out_busy;
      end
      default: begin
        cmd.act = mhpq_pkg::ACT_NONE;
      end
    endcase
  end

endmodule

// ----- rtl/core/mhpq_datapath.sv -----
// datapath of the heap queue: heap memory, hole/moving-entry registers,
// entry count, search index and result/output registers; depends on mhpq_pkg
module mhpq_datapath #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mhpq_pkg::cmd_t             cmd,
  output mhpq_pkg::sts_t             sts,
  input  logic [mhpq_pkg::ID_W-1:0]  req_node_id,
  input  logic [mhpq_pkg::KEY_W-1:0] req_distance,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [mhpq_pkg::ID_W-1:0]  out_node_id,
  output logic [mhpq_pkg::KEY_W-1:0] out_distance,
  output logic [mhpq_pkg::ST_W-1:0]  out_status
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CHD_W = IDX_W + 2;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  mhpq_pkg::entry_t mem [CAPACITY];

  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [IDX_W-1:0]            hole_r, hole_nxt;
  logic [IDX_W-1:0]            srch_idx_r, srch_idx_nxt;
  mhpq_pkg::entry_t            mv_r, mv_nxt;
  mhpq_pkg::entry_t            rd_a_r, rd_b_r;
  logic [mhpq_pkg::ID_W-1:0]   res_id_r, res_id_nxt;
  logic [mhpq_pkg::KEY_W-1:0]  res_key_r, res_key_nxt;
  mhpq_pkg::status_t           res_st_r, res_st_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [mhpq_pkg::ID_W-1:0]   out_id_r, out_id_nxt;
  logic [mhpq_pkg::KEY_W-1:0]  out_key_r, out_key_nxt;
  mhpq_pkg::status_t           out_st_r, out_st_nxt;

  logic [IDX_W-1:0]            hole_m1, parent_idx, scan_next, last_idx, child_idx;
  logic [CNT_W-1:0]            cnt_m1;
  logic [CHD_W-1:0]            left_idx, right_idx, cnt_ext;
  logic                        right_ok, pick_right;
  mhpq_pkg::entry_t            child;
  logic [IDX_W-1:0]            rd_addr_a, rd_addr_b;
  logic                        wr_en;
  mhpq_pkg::entry_t            wr_data;

  // heap index arithmetic
  assign hole_m1    = hole_r - 1'b1;
  assign parent_idx = hole_m1 >> 1;
  assign left_idx   = {1'b0, hole_r, 1'b1};
  assign right_idx  = left_idx + CHD_W'(1);
  assign cnt_ext    = CHD_W'(cnt_r);
  assign cnt_m1     = cnt_r - 1'b1;
  assign last_idx   = cnt_m1[IDX_W-1:0];
  assign scan_next  = srch_idx_r + 1'b1;

  // smaller child, left wins a tie
  assign right_ok   = right_idx < cnt_ext;
  assign pick_right = right_ok && (rd_b_r.key < rd_a_r.key);
  assign child      = pick_right ? rd_b_r : rd_a_r;
  assign child_idx  = pick_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];

  always_comb begin
    rd_addr_a = '0;
    rd_addr_b = last_idx;
    unique case (cmd.rd)
      mhpq_pkg::RD_ROOT_LAST: begin
        rd_addr_a = '0;
        rd_addr_b = last_idx;
      end
      mhpq_pkg::RD_SCAN: begin
        rd_addr_a = scan_next;
      end
      mhpq_pkg::RD_PARENT: begin
        rd_addr_a = parent_idx;
      end
      mhpq_pkg::RD_CHILDREN: begin
        rd_addr_a = left_idx[IDX_W-1:0];
        rd_addr_b = right_idx[IDX_W-1:0];
      end
      default: begin
        rd_addr_a = '0;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = mv_r;
    if (cmd.place) begin
      wr_en   = 1'b1;
      wr_data = mv_r;
    end else if (cmd.act == mhpq_pkg::ACT_UP_MOVE) begin
      wr_en   = 1'b1;
      wr_data = rd_a_r;
    end else if (cmd.act == mhpq_pkg::ACT_DN_MOVE) begin
      wr_en   = 1'b1;
      wr_data = child;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[hole_r] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  always_comb begin
    cnt_nxt      = cnt_r;
    hole_nxt     = hole_r;
    srch_idx_nxt = srch_idx_r;
    mv_nxt       = mv_r;
    res_id_nxt   = res_id_r;
    res_key_nxt  = res_key_r;
    res_st_nxt   = res_st_r;
    case (cmd.act)
      mhpq_pkg::ACT_LOAD, mhpq_pkg::ACT_LOAD_INS: begin
        mv_nxt.key   = req_distance;
        mv_nxt.id    = req_node_id;
        srch_idx_nxt = '0;
        res_id_nxt   = '0;
        res_key_nxt  = '0;
        res_st_nxt   = mhpq_pkg::ST_OK;
        if (cmd.act == mhpq_pkg::ACT_LOAD_INS) begin
          hole_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      mhpq_pkg::ACT_POP_TAKE: begin
        res_id_nxt  = rd_a_r.id;
        res_key_nxt = rd_a_r.key;
        mv_nxt      = rd_b_r;
        cnt_nxt     = cnt_m1;
        hole_nxt    = '0;
      end
      mhpq_pkg::ACT_SCAN: begin
        srch_idx_nxt = scan_next;
      end
      mhpq_pkg::ACT_FOUND: begin
        hole_nxt = srch_idx_r;
      end
      mhpq_pkg::ACT_UP_MOVE: begin
        hole_nxt = parent_idx;
      end
      mhpq_pkg::ACT_DN_MOVE: begin
        hole_nxt = child_idx;
      end
      default: begin
        hole_nxt = hole_r;
      end
    endcase
    if (cmd.set_status) begin
      res_st_nxt = cmd.status;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_id_nxt    = out_id_r;
    out_key_nxt   = out_key_r;
    out_st_nxt    = out_st_r;
    if (cmd.push_out) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = res_id_r;
      out_key_nxt   = res_key_r;
      out_st_nxt    = res_st_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hole_r     <= hole_nxt;
    srch_idx_r <= srch_idx_nxt;
    mv_r       <= mv_nxt;
    res_id_r   <= res_id_nxt;
    res_key_r  <= res_key_nxt;
    res_st_r   <= res_st_nxt;
    out_id_r   <= out_id_nxt;
    out_key_r  <= out_key_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.cnt_full  = (cnt_r == CNT_FULL);
  assign sts.hole_zero = (hole_r == '0);
  assign sts.leaf      = (left_idx >= cnt_ext);
  assign sts.parent_gt = (rd_a_r.key > mv_r.key);
  assign sts.child_lt  = (child.key < mv_r.key);
  assign sts.id_match  = (rd_a_r.id == mv_r.id);
  assign sts.scan_last = ((CNT_W'(srch_idx_r) + CNT_W'(1)) == cnt_r);
  assign sts.key_lt    = (mv_r.key < rd_a_r.key);
  assign sts.key_gt    = (mv_r.key > rd_a_r.key);
  assign sts.out_busy  = out_valid_r && !out_ready;

  assign out_valid    = out_valid_r;
  assign out_node_id  = out_id_r;
  assign out_distance = out_key_r;
  assign out_status   = out_st_r;

endmodule

// ----- rtl/core/min_heap_priority_queue_unit.sv -----
// Binary min-heap priority queue of (node id, distance) entries keyed on
// distance, CAPACITY entries deep in one two-read, one-write memory. Each
// request gives exactly one result. Insert places the new entry at the end and
// sifts it up while its parent is larger; pop takes the root, moves the last
// entry to the root and sifts it down while its smaller child is smaller; an
// entry equal to its parent or child stays put. Update first scans the heap
// from the root at one entry per cycle (up to the entry count) and then sifts
// like insert or pop. Every sift level is one memory read then one
// compare-and-write. A finished result sits in an output register, so the
// next request is taken while it waits. No clearing pass is needed after reset.
// depends on mhpq_pkg, mhpq_req_if, mhpq_rsp_if, mhpq_ctrl, mhpq_datapath
module min_heap_priority_queue_unit #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mhpq_req_if.sink  in_chan,
  mhpq_rsp_if.source out_chan
);

  mhpq_pkg::cmd_t cmd;
  mhpq_pkg::sts_t sts;

  mhpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_op    (in_chan.op),
    .in_ready (in_chan.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  mhpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .req_node_id  (in_chan.node_id),
    .req_distance (in_chan.distance),
    .out_ready    (out_chan.ready),
    .out_valid    (out_chan.valid),
    .out_node_id  (out_chan.out_node_id),
    .out_distance (out_chan.out_distance),
    .out_status   (out_chan.status)
  );

endmodule

// ----- rtl/core/mhpq_checker.sv -----
// port-level checks of the heap queue, bound onto the top level
// depends on mhpq_pkg and assert_macros.svh
`include "assert_macros.svh"

module mhpq_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mhpq_pkg::ID_W-1:0]  out_node_id,
  input logic [mhpq_pkg::KEY_W-1:0] out_distance,
  input logic [mhpq_pkg::ST_W-1:0]  out_status
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r, pend_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `MHPQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid)
  `MHPQ_ASSERT(a_no_extra_result, out_acc |-> (pend_r != 2'd0))
  `MHPQ_ASSERT(a_pending_bound, pend_r != 2'd3)
  `MHPQ_ASSERT(a_error_zero, (out_valid && (out_status != mhpq_pkg::ST_OK)) |-> ((out_node_id == '0) && (out_distance == '0)))
  `MHPQ_ASSERT(a_stall_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_node_id) && $stable(out_distance) && $stable(out_status)))

endmodule

bind min_heap_priority_queue_unit mhpq_checker u_mhpq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_node_id  (out_chan.out_node_id),
  .out_distance (out_chan.out_distance),
  .out_status   (out_chan.status)
);
